@@ hdl/smpt_pkg.sv @@
package smpt_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // divider: 16-bit dividend, 4 quotient bits per cycle
    localparam int DIV_W          = 16;
    localparam int BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES     = DIV_W / BITS_PER_CYCLE;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [7:0] ID_BYTE   = 8'd77;
    localparam logic [1:0] PKT_SYNC  = 2'b01;

    typedef enum logic {
        OP_POLL = 1'b0,
        OP_SYNC = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2,
        CFG_HOLD   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic load_poll;
        logic load_sync;
        logic div_step;
        logic push0;
        logic push1;
        logic push2;
        logic sync_commit;
    } cmd_t;

    typedef struct packed {
        logic hold;
        logic pkt_ok;
        logic send_ok;
        logic out_busy;
    } sts_t;

    typedef struct packed {
        logic [3:0]       rem;
        logic [DIV_W-1:0] dvd;
    } div_st_t;

    // one divider step of restoring division, BITS_PER_CYCLE quotient bits shift into dvd
    function automatic div_st_t div_iter(div_st_t s, logic [3:0] d);
        div_st_t    r;
        logic [4:0] t;
        r = s;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            t     = {r.rem, r.dvd[DIV_W-1]};
            r.dvd = {r.dvd[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                r.rem    = 4'(t - {1'b0, d});
                r.dvd[0] = 1'b1;
            end
            else
            begin
                r.rem = t[3:0];
            end
        end
        return r;
    endfunction

    // 50 / scale, zero scale taken as one
    function automatic logic [7:0] edge_step(logic [3:0] s);
        logic [7:0] v;
        case (s)
            4'd0, 4'd1:         v = 8'd50;
            4'd2:               v = 8'd25;
            4'd3:               v = 8'd16;
            4'd4:               v = 8'd12;
            4'd5:               v = 8'd10;
            4'd6:               v = 8'd8;
            4'd7:               v = 8'd7;
            4'd8:               v = 8'd6;
            4'd9, 4'd10:        v = 8'd5;
            4'd11, 4'd12:       v = 8'd4;
            default:            v = 8'd3;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/serial_mouse_packet_transmitter.sv @@
// Serial mouse transmitter: poll transfers (op 0) sample pointer and buttons and,
// when something moved or a button changed while RTS is high, queue a three-byte
// packet in a 64-byte FIFO (dropped whole if fewer than three slots are free);
// sync transfers (op 1) stand for one serial slot and send the FIFO head while
// RTS and DTR are high and no mouse reset is pending, while RTS low with DTR high
// clears the FIFO and queues the 'M' identification byte. Input items are taken
// one at a time: a poll holds the input until it has gone through the transfer
// cycle, the states of the radix-16 divider, four quotient bits per cycle on both
// axis lanes at once, and the packet check, which also writes the first byte, and
// when a packet is queued a FIFO write state for each further byte. A sync takes
// the transfer and the sync state (the FIFO head is read at the transfer edge,
// the commit follows in the sync state), which lasts longer only while the output
// register is still full. A poll with hold_polling set is absorbed in the transfer
// cycle. Configuration writes are always ready and take effect the next cycle.
module serial_mouse_packet_transmitter (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic signed [12:0]                pointer_x,
    input  logic signed [12:0]                pointer_y,
    input  logic                              left_button,
    input  logic                              right_button,
    input  logic                              rts,
    input  logic                              dtr,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    // bytes to the host
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        host_byte
);

    smpt_pkg::cmd_t cmd;
    smpt_pkg::sts_t sts;

    // sequencer: accept, divide, push bytes, sync commit
    smpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // config, dividers, FIFO pointers and RAM, output register
    smpt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .pointer_x    (pointer_x),
        .pointer_y    (pointer_y),
        .left_button  (left_button),
        .right_button (right_button),
        .rts          (rts),
        .dtr          (dtr),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .host_byte    (host_byte)
    );

endmodule

@@ hdl/smpt_ram.sv @@
module smpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/smpt_ctrl.sv @@
module smpt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              op,
    input  smpt_pkg::sts_t    sts,
    output logic              in_ready,
    output smpt_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_PUSH0 = 6'b000100,
        ST_PUSH1 = 6'b001000,
        ST_PUSH2 = 6'b010000,
        ST_SYNC  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [smpt_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == smpt_pkg::OP_SYNC)
                    begin
                        cmd.load_sync = 1'b1;
                        state_next    = ST_SYNC;
                    end
                    else if (!sts.hold)
                    begin
                        cmd.load_poll = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == smpt_pkg::DIV_CNT_W'(smpt_pkg::DIV_CYCLES - 1))
                begin
                    state_next = ST_PUSH0;
                end
            end
            ST_PUSH0:
            begin
                if (sts.pkt_ok)
                begin
                    cmd.push0  = 1'b1;
                    state_next = ST_PUSH1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH1:
            begin
                cmd.push1  = 1'b1;
                state_next = ST_PUSH2;
            end
            ST_PUSH2:
            begin
                cmd.push2  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SYNC:
            begin
                if (!(sts.send_ok && sts.out_busy))
                begin
                    cmd.sync_commit = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ hdl/smpt_dp.sv @@
module smpt_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  smpt_pkg::cmd_t                    cmd,
    output smpt_pkg::sts_t                    sts,
    input  logic signed [12:0]                pointer_x,
    input  logic signed [12:0]                pointer_y,
    input  logic                              left_button,
    input  logic                              right_button,
    input  logic                              rts,
    input  logic                              dtr,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [smpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        host_byte
);

    localparam int PW = smpt_pkg::PTR_W;
    localparam int CW = smpt_pkg::CNT_W;

    // configuration
    logic [3:0]  scale_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic        hold_reg;

    // persistent state
    logic [12:0] last_x_reg, last_y_reg;
    logic [1:0]  last_btn_reg;
    logic        rp_reg, rp_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  host_byte_reg;

    // per-item payload
    smpt_pkg::div_st_t lane_x_reg, lane_y_reg;
    logic        neg_x_reg, neg_y_reg;
    logic        lo_x_reg, lo_y_reg;
    logic        hi_x_reg, hi_y_reg;
    logic [1:0]  btn_reg;
    logic        btn_chg_reg;
    logic        rts_reg, dtr_reg;

    logic [3:0]  div_eff;
    logic [7:0]  force_val;
    logic [13:0] diff_x, diff_y, mag_x, mag_y;
    logic [7:0]  dx, dy;
    logic        send_go, reset_go;
    logic        ram_we;
    logic [PW-1:0] ram_waddr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic [PW-1:0] tail_inc;

    function automatic logic [7:0] axis_delta(logic [6:0] q, logic neg, logic lo,
                                              logic hi, logic [7:0] f);
        logic [7:0] q2;
        logic [7:0] d;
        q2 = {q, 1'b0};
        d  = neg ? 8'(8'd0 - q2) : q2;
        if (lo)
        begin
            d = 8'(8'd0 - f);
        end
        if (hi)
        begin
            d = f;
        end
        return d;
    endfunction

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(smpt_pkg::FIFO_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign cfg_ready = 1'b1;
    assign div_eff   = (scale_reg == 4'd0) ? 4'd1 : scale_reg;
    assign force_val = smpt_pkg::edge_step(scale_reg);

    assign diff_x = 14'({pointer_x[12], pointer_x} - {last_x_reg[12], last_x_reg});
    assign diff_y = 14'({pointer_y[12], pointer_y} - {last_y_reg[12], last_y_reg});
    assign mag_x  = diff_x[13] ? 14'(14'd0 - diff_x) : diff_x;
    assign mag_y  = diff_y[13] ? 14'(14'd0 - diff_y) : diff_y;

    assign dx = axis_delta(lane_x_reg.dvd[6:0], neg_x_reg, lo_x_reg, hi_x_reg, force_val);
    assign dy = axis_delta(lane_y_reg.dvd[6:0], neg_y_reg, lo_y_reg, hi_y_reg, force_val);

    assign send_go  = (count_reg != '0) && rts_reg && dtr_reg && !rp_reg;
    assign reset_go = !rts_reg && dtr_reg && !rp_reg;

    assign sts.hold     = hold_reg;
    assign sts.pkt_ok   = ((dx != 8'd0) || (dy != 8'd0) || btn_chg_reg) && rts_reg
                          && (count_reg <= CW'(smpt_pkg::FIFO_DEPTH - 3));
    assign sts.send_ok  = send_go;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign tail_inc = ptr_inc(tail_reg);

    // FIFO write port
    always_comb
    begin
        ram_we    = cmd.push0 || cmd.push1 || cmd.push2;
        ram_waddr = tail_reg;
        ram_wdata = {smpt_pkg::PKT_SYNC, btn_reg, dy[7:6], dx[7:6]};
        if (cmd.push1)
        begin
            ram_wdata = {2'b00, dx[5:0]};
        end
        if (cmd.push2)
        begin
            ram_wdata = {2'b00, dy[5:0]};
        end
        if (cmd.sync_commit && reset_go)
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = smpt_pkg::ID_BYTE;
        end
    end

    // pointers, reset handshake, output slot
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rp_next        = rp_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.push0 || cmd.push1 || cmd.push2)
        begin
            tail_next  = tail_inc;
            count_next = CW'(count_reg + 1'b1);
        end
        if (cmd.sync_commit)
        begin
            if (send_go)
            begin
                head_next      = ptr_inc(head_reg);
                count_next     = CW'(count_reg - 1'b1);
                out_valid_next = 1'b1;
            end
            if (rp_reg && rts_reg && dtr_reg)
            begin
                rp_next = 1'b0;
            end
            if (reset_go)
            begin
                head_next  = '0;
                tail_next  = ptr_inc('0);
                count_next = CW'(1);
                rp_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= 4'd1;
            width_reg     <= 12'd640;
            height_reg    <= 12'd400;
            hold_reg      <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_btn_reg  <= '0;
            rp_reg        <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    smpt_pkg::CFG_SCALE:  scale_reg  <= cfg_data[3:0];
                    smpt_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    smpt_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    smpt_pkg::CFG_HOLD:   hold_reg   <= cfg_data[0];
                    default:              hold_reg   <= hold_reg;
                endcase
            end
            if (cmd.load_poll)
            begin
                last_x_reg   <= pointer_x;
                last_y_reg   <= pointer_y;
                last_btn_reg <= {left_button, right_button};
            end
            rp_reg        <= rp_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // per-item payload, divider lanes
    always_ff @(posedge clk)
    begin
        if (cmd.load_poll || cmd.load_sync)
        begin
            rts_reg <= rts;
            dtr_reg <= dtr;
        end
        if (cmd.load_poll)
        begin
            lane_x_reg  <= '{rem: 4'd0, dvd: smpt_pkg::DIV_W'(mag_x[12:0])};
            lane_y_reg  <= '{rem: 4'd0, dvd: smpt_pkg::DIV_W'(mag_y[12:0])};
            neg_x_reg   <= diff_x[13];
            neg_y_reg   <= diff_y[13];
            lo_x_reg    <= pointer_x[12];
            lo_y_reg    <= pointer_y[12];
            hi_x_reg    <= $signed({pointer_x[12], pointer_x}) > $signed({2'b00, width_reg});
            hi_y_reg    <= $signed({pointer_y[12], pointer_y}) > $signed({2'b00, height_reg});
            btn_reg     <= {left_button, right_button};
            btn_chg_reg <= ({left_button, right_button} != last_btn_reg);
        end
        if (cmd.div_step)
        begin
            lane_x_reg <= smpt_pkg::div_iter(lane_x_reg, div_eff);
            lane_y_reg <= smpt_pkg::div_iter(lane_y_reg, div_eff);
        end
        if (cmd.sync_commit && send_go)
        begin
            host_byte_reg <= ram_rdata;
        end
    end

    // read port follows the head; the registered read data is ready in the sync state that follows a sync transfer
    smpt_ram #(
        .WIDTH (8),
        .DEPTH (smpt_pkg::FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign host_byte = host_byte_reg;

endmodule

@@ hdl/smpt_checker.sv @@
module smpt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              op,
    input logic                              rts,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [7:0]                        host_byte
);

    // stalled output holds its byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(host_byte))
        else $error("host byte changed while stalled");

    // a sync transfer makes the block busy in the cycle after it
    a_sync_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op |=> !in_ready)
        else $error("input ready right after sync transfer");

    // a new byte only comes out of the sync commit cycle
    a_out_from_sync: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("output appeared without a sync in progress");

    // sync with RTS low never sends a byte
    a_no_send_rts_low: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op && !rts |=> ##1 !$rose(out_valid))
        else $error("byte sent with RTS low");

endmodule

bind serial_mouse_packet_transmitter smpt_checker u_smpt_checker (.*);
